// ===== src/jhcg_pkg.sv =====
// Shared types and constants for the JPEG canonical Huffman code generator.
// Used by jhcg_store, jhcg_stepper and jpeg_huffman_code_generator. No dependencies.
package jhcg_pkg;

  localparam int DEF_MAX_CODE_LENGTH = 16;

  localparam int OP_W   = 2;
  localparam int CNT_W  = 8;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;
  localparam int RUN_W  = 17;
  localparam int SLOT_W = 8;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Commands from the sequencer to the code state.
  typedef struct packed {
    logic clear;
    logic step;
    logic commit;
  } jhcg_ctl_t;

  // Status of the code state seen by the sequencer.
  typedef struct packed {
    logic              need_step;
    logic              exhausted;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } jhcg_stat_t;

endpackage

// ===== src/jhcg_store.sv =====
// Per-length code count store with its load pointer.
// Depends on jhcg_pkg.
module jhcg_store #(
  parameter int MAX_CODE_LENGTH = jhcg_pkg::DEF_MAX_CODE_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       clear,
  input  logic [jhcg_pkg::CNT_W-1:0] load_count,
  input  logic [jhcg_pkg::LEN_W-1:0] rd_len,
  output logic [jhcg_pkg::CNT_W-1:0] rd_count
);
  import jhcg_pkg::*;

  localparam int IDX_W = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
  localparam int LD_W  = $clog2(MAX_CODE_LENGTH + 1);

  logic [CNT_W-1:0] store_r [MAX_CODE_LENGTH];
  logic [LD_W-1:0]  loaded_r;
  logic [LEN_W-1:0] rd_off;
  logic [IDX_W-1:0] rd_idx;
  logic             room;

  assign room   = loaded_r < LD_W'(MAX_CODE_LENGTH);
  assign rd_off = rd_len - LEN_W'(1);
  assign rd_idx = rd_off[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      loaded_r <= '0;
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (load && room) begin
      store_r[loaded_r[IDX_W-1:0]] <= load_count;
      loaded_r                     <= loaded_r + LD_W'(1);
    end
  end

  // Lengths outside the table hold no codes.
  always_comb begin
    rd_count = '0;
    if (rd_len != '0 && rd_len <= LEN_W'(MAX_CODE_LENGTH)) begin
      rd_count = store_r[rd_idx];
    end
  end

endmodule

// ===== src/jhcg_stepper.sv =====
// Canonical code state: current length, codes used at it and the running code.
// One compare-and-shift step per cycle under control of the top-level sequencer.
// Depends on jhcg_pkg.
module jhcg_stepper #(
  parameter int MAX_CODE_LENGTH = jhcg_pkg::DEF_MAX_CODE_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jhcg_pkg::jhcg_ctl_t        ctl,
  input  logic [jhcg_pkg::CNT_W-1:0] count,
  output logic [jhcg_pkg::LEN_W-1:0] cur_length,
  output jhcg_pkg::jhcg_stat_t       stat
);
  import jhcg_pkg::*;

  logic [LEN_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [RUN_W-1:0] code_r, code_nxt;
  logic [RUN_W-1:0] mask;
  logic             in_range;

  assign in_range   = cur_r <= LEN_W'(MAX_CODE_LENGTH);
  assign cur_length = cur_r;
  assign mask       = (RUN_W'(1) << cur_r) - RUN_W'(1);

  always_comb begin
    stat.need_step   = in_range && (used_r >= count);
    stat.exhausted   = !in_range;
    stat.code_bits   = code_r[CODE_W-1:0] & mask[CODE_W-1:0];
    stat.code_length = cur_r;
  end

  always_comb begin
    cur_nxt  = cur_r;
    used_nxt = used_r;
    code_nxt = code_r;
    if (ctl.clear) begin
      cur_nxt  = LEN_W'(1);
      used_nxt = '0;
      code_nxt = '0;
    end else if (ctl.step) begin
      // Move to the next length; the code doubles only while a length remains.
      cur_nxt  = cur_r + LEN_W'(1);
      used_nxt = '0;
      if (cur_r < LEN_W'(MAX_CODE_LENGTH)) begin
        code_nxt = {code_r[RUN_W-2:0], 1'b0};
      end
    end else if (ctl.commit && in_range) begin
      used_nxt = used_r + CNT_W'(1);
      code_nxt = code_r + RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= LEN_W'(1);
      used_r <= '0;
      code_r <= '0;
    end else begin
      cur_r  <= cur_nxt;
      used_r <= used_nxt;
      code_r <= code_nxt;
    end
  end

endmodule

// ===== src/jpeg_huffman_code_generator.sv =====
// JPEG canonical Huffman code generator, top level: sequencer, handshake and result register.
// Count loads and restarts are taken in S_IDLE, which they do not leave. An assigned symbol
// moves to S_STEP, which skips k empty or used-up code lengths, 0 to MAX_CODE_LENGTH, one per
// cycle through the shared compare-and-shift step of jhcg_stepper, then stores its result once
// the result register is free; in_ready stays low until then. rst_n is synchronous and active
// low; it empties the count store, sets the code length to one and drops out_valid.
module jpeg_huffman_code_generator #(
  parameter int MAX_CODE_LENGTH = jhcg_pkg::DEF_MAX_CODE_LENGTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jhcg_pkg::OP_W-1:0]   in_opcode,
  input  logic [jhcg_pkg::CNT_W-1:0]  in_length_count,
  input  logic [jhcg_pkg::SYM_W-1:0]  in_symbol_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jhcg_pkg::CODE_W-1:0] out_code_bits,
  output logic [jhcg_pkg::LEN_W-1:0]  out_code_length,
  output logic [jhcg_pkg::SLOT_W-1:0] out_table_index,
  output logic [jhcg_pkg::SYM_W-1:0]  out_symbol_echo,
  output logic                        out_status
);
  import jhcg_pkg::*;

  localparam logic [3:0] NIBBLE_ALL = 4'hF;

  typedef enum logic {
    S_IDLE,
    S_STEP
  } state_t;

  state_t           state_r, state_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] code_bits_r, code_bits_nxt;
  logic [LEN_W-1:0]  code_length_r, code_length_nxt;
  logic [SLOT_W-1:0] table_index_r, table_index_nxt;
  logic [SYM_W-1:0]  symbol_echo_r, symbol_echo_nxt;
  logic              status_r, status_nxt;

  logic             in_xfer;
  logic             finish;
  logic [3:0]       run;
  logic [3:0]       size;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] cur_length;
  jhcg_ctl_t        ctl;
  jhcg_stat_t       stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // A symbol finishes once no length needs skipping and the result register is free.
  assign finish = (state_r == S_STEP) && !stat.need_step && (!out_valid_r || out_ready);

  always_comb begin
    ctl.clear  = in_xfer && (in_opcode == OP_RESTART);
    ctl.step   = (state_r == S_STEP) && stat.need_step;
    ctl.commit = finish;
  end

  jhcg_store #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer && (in_opcode == OP_LOAD)),
    .clear     (ctl.clear),
    .load_count(in_length_count),
    .rd_len    (cur_length),
    .rd_count  (count)
  );

  jhcg_stepper #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .count     (count),
    .cur_length(cur_length),
    .stat      (stat)
  );

  // Table slot: run times ten plus size, with one extra when the run nibble is all ones.
  assign run  = sym_r[7:4];
  assign size = sym_r[3:0];
  assign slot = {1'b0, run, 3'b000} + {3'b000, run, 1'b0} + {4'b0000, size}
              + {{(SLOT_W-1){1'b0}}, (run == NIBBLE_ALL)};

  always_comb begin
    state_nxt       = state_r;
    sym_nxt         = sym_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    code_bits_nxt   = code_bits_r;
    code_length_nxt = code_length_r;
    table_index_nxt = table_index_r;
    symbol_echo_nxt = symbol_echo_r;
    status_nxt      = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_opcode == OP_ASSIGN)) begin
          sym_nxt   = in_symbol_value;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (finish) begin
          out_valid_nxt   = 1'b1;
          table_index_nxt = slot;
          symbol_echo_nxt = sym_r;
          status_nxt      = stat.exhausted;
          code_bits_nxt   = stat.exhausted ? '0 : stat.code_bits;
          code_length_nxt = stat.exhausted ? '0 : stat.code_length;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r         <= sym_nxt;
    code_bits_r   <= code_bits_nxt;
    code_length_r <= code_length_nxt;
    table_index_r <= table_index_nxt;
    symbol_echo_r <= symbol_echo_nxt;
    status_r      <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_bits   = code_bits_r;
  assign out_code_length = code_length_r;
  assign out_table_index = table_index_r;
  assign out_symbol_echo = symbol_echo_r;
  assign out_status      = status_r;

  // A finished symbol never overwrites a result that has not been transferred.
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP && !stat.need_step && out_valid_r && !out_ready) |=> state_r == S_STEP)
    else $error("symbol finished while result register was occupied");

  // An exhausted result carries no code.
  a_exhausted_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status) |-> (out_code_length == '0 && out_code_bits == '0))
    else $error("exhausted result carries a code");

  // An assigned code has a length inside the table.
  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_status) |->
      (out_code_length != '0 && out_code_length <= LEN_W'(MAX_CODE_LENGTH)))
    else $error("assigned code length out of range");

  // Skipping a length never happens outside symbol processing.
  a_step_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> (state_r == S_STEP && !in_ready))
    else $error("length step outside symbol processing");

endmodule
